/* hw/rtl/vae_pkg.sv */
package vae_pkg;

  // Defaults for the top-level parameters
  localparam int COORD_WIDTH_DEF     = 32;
  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int CORDIC_STEPS_DEF    = 20;

  // Rotation datapath: coordinates are scaled so their sign sits at bit 59
  localparam int DP_W      = 64;
  localparam int SCALE_MSB = 60;
  localparam int ZMAG_W    = 60;
  localparam int ZLO_W     = 32;
  localparam int ZHI_W     = ZMAG_W - ZLO_W;
  localparam int GAIN_W    = 32;

  // Angles: degrees, 48 fraction bits, signed, covers +-512 degrees
  localparam int ANG_Q = 48;
  localparam int ANG_W = 58;

  // K/2 in Q32, K = CORDIC gain limit
  localparam logic [GAIN_W-1:0] HALF_GAIN_Q32   = 32'd3536390726;
  // 180/pi in Q48
  localparam logic [63:0]       DEG_PER_RAD_Q48 = 64'd16127328204063727;

  localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180) <<< ANG_Q;
  localparam logic signed [ANG_W-1:0] ANG_360 = ANG_W'(360) <<< ANG_Q;

  // One item in flight through the rotation stages
  typedef struct packed {
    logic signed [DP_W-1:0]  x;
    logic signed [DP_W-1:0]  y;
    logic signed [ANG_W-1:0] ang;     // angle accumulated by this pass
    logic signed [DP_W-1:0]  zk;      // K * z, carried through the azimuth pass
    logic signed [ANG_W-1:0] az_ang;  // azimuth result, carried through elevation pass
    logic                    xy_zero;
    logic                    all_zero;
  } vae_vec_t;

  // atan(2^-step) in degrees, Q48. Truncated alternating series for step >= 1;
  // every partial sum stays positive, so unsigned arithmetic is safe.
  function automatic logic [63:0] vae_atan_entry(input int step);
    logic [63:0] acc;
    if (step == 0) begin
      acc = 64'd45 << ANG_Q;
    end else begin
      acc = DEG_PER_RAD_Q48 >> step;
      acc = acc - (DEG_PER_RAD_Q48 >> (3 * step)) / 3;
      acc = acc + (DEG_PER_RAD_Q48 >> (5 * step)) / 5;
      acc = acc - (DEG_PER_RAD_Q48 >> (7 * step)) / 7;
      acc = acc + (DEG_PER_RAD_Q48 >> (9 * step)) / 9;
      acc = acc - (DEG_PER_RAD_Q48 >> (11 * step)) / 11;
      acc = acc + (DEG_PER_RAD_Q48 >> (13 * step)) / 13;
      acc = acc - (DEG_PER_RAD_Q48 >> (15 * step)) / 15;
      acc = acc + (DEG_PER_RAD_Q48 >> (17 * step)) / 17;
      acc = acc - (DEG_PER_RAD_Q48 >> (19 * step)) / 19;
      acc = acc + (DEG_PER_RAD_Q48 >> (21 * step)) / 21;
      acc = acc - (DEG_PER_RAD_Q48 >> (23 * step)) / 23;
      acc = acc + (DEG_PER_RAD_Q48 >> (25 * step)) / 25;
      acc = acc - (DEG_PER_RAD_Q48 >> (27 * step)) / 27;
      acc = acc + (DEG_PER_RAD_Q48 >> (29 * step)) / 29;
      acc = acc - (DEG_PER_RAD_Q48 >> (31 * step)) / 31;
      acc = acc + (DEG_PER_RAD_Q48 >> (33 * step)) / 33;
      acc = acc - (DEG_PER_RAD_Q48 >> (35 * step)) / 35;
      acc = acc + (DEG_PER_RAD_Q48 >> (37 * step)) / 37;
      acc = acc - (DEG_PER_RAD_Q48 >> (39 * step)) / 39;
      acc = acc + (DEG_PER_RAD_Q48 >> (41 * step)) / 41;
      acc = acc - (DEG_PER_RAD_Q48 >> (43 * step)) / 43;
      acc = acc + (DEG_PER_RAD_Q48 >> (45 * step)) / 45;
      acc = acc - (DEG_PER_RAD_Q48 >> (47 * step)) / 47;
      acc = acc + (DEG_PER_RAD_Q48 >> (49 * step)) / 49;
      acc = acc - (DEG_PER_RAD_Q48 >> (51 * step)) / 51;
      acc = acc + (DEG_PER_RAD_Q48 >> (53 * step)) / 53;
      acc = acc - (DEG_PER_RAD_Q48 >> (55 * step)) / 55;
      acc = acc + (DEG_PER_RAD_Q48 >> (57 * step)) / 57;
      acc = acc - (DEG_PER_RAD_Q48 >> (59 * step)) / 59;
      acc = acc + (DEG_PER_RAD_Q48 >> (61 * step)) / 61;
      acc = acc - (DEG_PER_RAD_Q48 >> (63 * step)) / 63;
    end
    return acc;
  endfunction

endpackage

/* hw/rtl/vae_cordic_step.sv */
module vae_cordic_step #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  vae_pkg::vae_vec_t in_vec,
  output logic              out_valid,
  output vae_pkg::vae_vec_t out_vec
);
  import vae_pkg::*;

  localparam logic signed [ANG_W-1:0] ATAN = ANG_W'(vae_atan_entry(STEP));

  logic signed [DP_W-1:0] dx;
  logic signed [DP_W-1:0] dy;
  vae_vec_t               vec_nxt;
  vae_vec_t               vec_r;
  logic                   valid_r;

  assign dx = in_vec.y >>> STEP;
  assign dy = in_vec.x >>> STEP;

  // Rotate toward y = 0; both updates use the old x and y
  always_comb begin
    vec_nxt = in_vec;
    if (!in_vec.y[DP_W-1]) begin
      vec_nxt.x   = in_vec.x + dx;
      vec_nxt.y   = in_vec.y - dy;
      vec_nxt.ang = in_vec.ang + ATAN;
    end else begin
      vec_nxt.x   = in_vec.x - dx;
      vec_nxt.y   = in_vec.y + dy;
      vec_nxt.ang = in_vec.ang - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vec_r <= vec_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_vec   = vec_r;

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(valid_r))
    else $error("stage valid changed during stall");

  a_vec_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !adv |=> $stable(vec_r))
    else $error("stage payload changed during stall");

  a_ang_step: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_valid |=> (vec_r.ang == $past(in_vec.ang) + ATAN) ||
                        (vec_r.ang == $past(in_vec.ang) - ATAN))
    else $error("angle moved by other than one table entry");

  a_side_carry: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_valid |=> (vec_r.az_ang == $past(in_vec.az_ang)) &&
                        (vec_r.all_zero == $past(in_vec.all_zero)) &&
                        (vec_r.xy_zero == $past(in_vec.xy_zero)))
    else $error("carried fields altered by rotation stage");

endmodule

/* hw/rtl/vector_azimuth_elevation.sv */
// Cartesian vector to azimuth / elevation, both in degrees.
//
// Input stream (in_*): one word per vector, x / y / z signed, same scale.
// Output stream (out_*): one word per input word, in order: azimuth in
// 0..<360 (unsigned, ANGLE_FRAC_BITS fraction bits) and elevation in
// -90..90 (signed, same fraction bits). A zero vector gives 0 / 0; zero x
// and y give azimuth 0 and elevation about +-90.
//
// Throughput: one word per clock, sustained while out_tready stays high.
// Path from acceptance to out_tvalid: three front stages (scale and fold,
// gain multiply, gain sum), CORDIC_STEPS azimuth rotations, CORDIC_STEPS
// elevation rotations, one rounding stage, then the output buffer.
//
// Reset clears every valid bit and empties the output buffer; payload
// registers are not reset. A two-word output buffer sits behind the
// pipeline: while the receiver stalls the pipeline keeps running until the
// buffer is full, then freezes as a whole and in_tready drops. No word is
// lost or repeated.
module vector_azimuth_elevation #(
  parameter int COORD_WIDTH     = vae_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = vae_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = vae_pkg::CORDIC_STEPS_DEF,
  localparam int IN_TDATA_W     = ((3 * COORD_WIDTH + 7) / 8) * 8,
  localparam int AZ_W           = ANGLE_FRAC_BITS + 9,
  localparam int EL_W           = ANGLE_FRAC_BITS + 8,
  localparam int OUT_TDATA_W    = ((AZ_W + EL_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // coord_x, coord_y, coord_z, zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // azimuth_deg, elevation_deg, zero pad
);
  import vae_pkg::*;

  localparam int GUARD     = SCALE_MSB - COORD_WIDTH;
  localparam int RND_SHIFT = ANG_Q - ANGLE_FRAC_BITS;
  localparam int RND_W     = ANG_W - RND_SHIFT;

  localparam logic signed [ANG_W-1:0] RND_HALF  = ANG_W'(1) <<< (RND_SHIFT - 1);
  localparam logic signed [RND_W-1:0] AZ_FULL   = RND_W'(360) <<< ANGLE_FRAC_BITS;
  localparam logic signed [RND_W-1:0] EL_RIGHT  = RND_W'(90) <<< ANGLE_FRAC_BITS;
  localparam logic signed [RND_W-1:0] EL_LEFT   = -EL_RIGHT;

  // Global advance: the whole pipeline moves unless the output buffer is full
  logic adv;

  // ---------------------------------------------------------------------------
  // Stage 1: sign-extend, scale to the common 60-bit range, fold left half-plane
  // ---------------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] cx;
  logic signed [COORD_WIDTH-1:0] cy;
  logic signed [COORD_WIDTH-1:0] cz;
  logic signed [DP_W-1:0]        xe;
  logic signed [DP_W-1:0]        ye;
  logic signed [DP_W-1:0]        ze;

  logic signed [DP_W-1:0] s1_x_nxt;
  logic signed [DP_W-1:0] s1_y_nxt;
  logic [ZMAG_W-1:0]      s1_zmag_nxt;
  logic                   s1_xy_zero_nxt;
  logic                   s1_all_zero_nxt;

  logic                   s1_valid_r;
  logic signed [DP_W-1:0] s1_x_r;
  logic signed [DP_W-1:0] s1_y_r;
  logic                   s1_xneg_r;
  logic [ZMAG_W-1:0]      s1_zmag_r;
  logic                   s1_zneg_r;
  logic                   s1_xy_zero_r;
  logic                   s1_all_zero_r;

  assign cx = in_tdata[COORD_WIDTH-1:0];
  assign cy = in_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign cz = in_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

  assign xe = DP_W'(cx) <<< GUARD;
  assign ye = DP_W'(cy) <<< GUARD;
  assign ze = DP_W'(cz) <<< GUARD;

  // x < 0: rotate by 180 degrees first so the vectoring stays in range
  assign s1_x_nxt        = cx[COORD_WIDTH-1] ? -xe : xe;
  assign s1_y_nxt        = cx[COORD_WIDTH-1] ? -ye : ye;
  assign s1_zmag_nxt     = ZMAG_W'(cz[COORD_WIDTH-1] ? -ze : ze);
  assign s1_xy_zero_nxt  = (cx == '0) && (cy == '0);
  assign s1_all_zero_nxt = s1_xy_zero_nxt && (cz == '0);

  assign in_tready = adv;

  // ---------------------------------------------------------------------------
  // Stage 2: |z| * K/2, split into two partial products at bit 32
  // ---------------------------------------------------------------------------
  logic [ZHI_W-1:0]           s1_zhi;
  logic [ZLO_W-1:0]           s1_zlo;
  logic [ZMAG_W-1:0]          s2_phi_nxt;
  logic [ZLO_W+GAIN_W-1:0]    plo_full;

  logic                   s2_valid_r;
  logic signed [DP_W-1:0] s2_x_r;
  logic signed [DP_W-1:0] s2_y_r;
  logic                   s2_xneg_r;
  logic [ZMAG_W-1:0]      s2_phi_r;
  logic [GAIN_W-1:0]      s2_plo_r;
  logic                   s2_zneg_r;
  logic                   s2_xy_zero_r;
  logic                   s2_all_zero_r;

  assign s1_zhi     = s1_zmag_r[ZMAG_W-1:ZLO_W];
  assign s1_zlo     = s1_zmag_r[ZLO_W-1:0];
  assign s2_phi_nxt = s1_zhi * HALF_GAIN_Q32;
  assign plo_full   = s1_zlo * HALF_GAIN_Q32;

  // ---------------------------------------------------------------------------
  // Stage 3: K*z = sign(z) * 2 * floor(|z| * K/2), build the rotation word
  // ---------------------------------------------------------------------------
  logic [ZMAG_W-1:0]      zsum;
  logic signed [DP_W-1:0] zk_mag;
  vae_vec_t               s3_vec_nxt;
  vae_vec_t               s3_vec_r;
  logic                   s3_valid_r;

  assign zsum   = s2_phi_r + ZMAG_W'(s2_plo_r);
  assign zk_mag = DP_W'({zsum, 1'b0});

  always_comb begin
    s3_vec_nxt          = '0;
    s3_vec_nxt.x        = s2_x_r;
    s3_vec_nxt.y        = s2_y_r;
    s3_vec_nxt.ang      = s2_xneg_r ? ANG_180 : ANG_W'(0);
    s3_vec_nxt.zk       = s2_zneg_r ? -zk_mag : zk_mag;
    s3_vec_nxt.xy_zero  = s2_xy_zero_r;
    s3_vec_nxt.all_zero = s2_all_zero_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x_r        <= s1_x_nxt;
      s1_y_r        <= s1_y_nxt;
      s1_xneg_r     <= cx[COORD_WIDTH-1];
      s1_zmag_r     <= s1_zmag_nxt;
      s1_zneg_r     <= cz[COORD_WIDTH-1];
      s1_xy_zero_r  <= s1_xy_zero_nxt;
      s1_all_zero_r <= s1_all_zero_nxt;

      s2_x_r        <= s1_x_r;
      s2_y_r        <= s1_y_r;
      s2_xneg_r     <= s1_xneg_r;
      s2_phi_r      <= s2_phi_nxt;
      s2_plo_r      <= plo_full[ZLO_W+GAIN_W-1:ZLO_W];
      s2_zneg_r     <= s1_zneg_r;
      s2_xy_zero_r  <= s1_xy_zero_r;
      s2_all_zero_r <= s1_all_zero_r;

      s3_vec_r      <= s3_vec_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Azimuth pass: vector (x, y) to y = 0, one rotation per stage
  // ---------------------------------------------------------------------------
  logic [CORDIC_STEPS:0] az_vld;
  vae_vec_t              az_vec [CORDIC_STEPS+1];

  assign az_vld[0] = s3_valid_r;
  assign az_vec[0] = s3_vec_r;

  genvar g;
  for (g = 0; g < CORDIC_STEPS; g++) begin : g_az
    vae_cordic_step #(
      .STEP(g)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (az_vld[g]),
      .in_vec    (az_vec[g]),
      .out_valid (az_vld[g+1]),
      .out_vec   (az_vec[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Elevation pass: vector (K*|xy|, K*z) from angle 0; x from the azimuth pass
  // already carries the gain K
  // ---------------------------------------------------------------------------
  logic [CORDIC_STEPS:0] el_vld;
  vae_vec_t              el_vec [CORDIC_STEPS+1];

  always_comb begin
    el_vec[0]          = '0;
    el_vec[0].x        = az_vec[CORDIC_STEPS].x;
    el_vec[0].y        = az_vec[CORDIC_STEPS].zk;
    el_vec[0].az_ang   = az_vec[CORDIC_STEPS].ang;
    el_vec[0].xy_zero  = az_vec[CORDIC_STEPS].xy_zero;
    el_vec[0].all_zero = az_vec[CORDIC_STEPS].all_zero;
  end
  assign el_vld[0] = az_vld[CORDIC_STEPS];

  for (g = 0; g < CORDIC_STEPS; g++) begin : g_el
    vae_cordic_step #(
      .STEP(g)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (el_vld[g]),
      .in_vec    (el_vec[g]),
      .out_valid (el_vld[g+1]),
      .out_vec   (el_vec[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Rounding stage: wrap azimuth into 0..360, round half up to output precision
  // ---------------------------------------------------------------------------
  logic signed [ANG_W-1:0] az_sum;
  logic signed [ANG_W-1:0] el_sum;

  logic                    fin_valid_r;
  logic signed [RND_W-1:0] fin_az_r;
  logic signed [RND_W-1:0] fin_el_r;
  logic                    fin_xy_zero_r;
  logic                    fin_all_zero_r;

  assign az_sum = el_vec[CORDIC_STEPS].az_ang
                + (el_vec[CORDIC_STEPS].az_ang[ANG_W-1] ? ANG_360 : ANG_W'(0))
                + RND_HALF;
  assign el_sum = el_vec[CORDIC_STEPS].ang + RND_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (adv) begin
      fin_valid_r <= el_vld[CORDIC_STEPS];
    end
  end

  // Upper part-select of the biased sum = floor shift
  always_ff @(posedge clk) begin
    if (adv) begin
      fin_az_r       <= az_sum[ANG_W-1:RND_SHIFT];
      fin_el_r       <= el_sum[ANG_W-1:RND_SHIFT];
      fin_xy_zero_r  <= el_vec[CORDIC_STEPS].xy_zero;
      fin_all_zero_r <= el_vec[CORDIC_STEPS].all_zero;
    end
  end

  // Final fix-ups: rounded 360 becomes 0, elevation clamped to +-90,
  // zero XY gives azimuth 0, zero vector gives elevation 0
  logic signed [RND_W-1:0] az_wrap;
  logic signed [RND_W-1:0] el_clamp;
  logic [AZ_W-1:0]         res_az;
  logic [EL_W-1:0]         res_el;

  always_comb begin
    az_wrap  = (fin_az_r >= AZ_FULL) ? fin_az_r - AZ_FULL : fin_az_r;
    el_clamp = fin_el_r;
    if (fin_el_r > EL_RIGHT) begin
      el_clamp = EL_RIGHT;
    end else if (fin_el_r < EL_LEFT) begin
      el_clamp = EL_LEFT;
    end
    res_az = fin_xy_zero_r  ? '0 : az_wrap[AZ_W-1:0];
    res_el = fin_all_zero_r ? '0 : el_clamp[EL_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Two-word output buffer; head word drives the output port
  // ---------------------------------------------------------------------------
  logic [1:0]      cnt_r;
  logic [1:0]      cnt_nxt;
  logic [AZ_W-1:0] head_az_r;
  logic [EL_W-1:0] head_el_r;
  logic [AZ_W-1:0] tail_az_r;
  logic [EL_W-1:0] tail_el_r;
  logic            push;
  logic            pop;

  assign adv        = (cnt_r != 2'd2);
  assign push       = fin_valid_r && adv;
  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && ((cnt_r == 2'd0) || (cnt_r == 2'd1 && pop))) begin
      head_az_r <= res_az;
      head_el_r <= res_el;
    end else if (pop && cnt_r == 2'd2) begin
      head_az_r <= tail_az_r;
      head_el_r <= tail_el_r;
    end
    if (push && !pop && cnt_r == 2'd1) begin
      tail_az_r <= res_az;
      tail_el_r <= res_el;
    end
  end

  assign out_tdata = OUT_TDATA_W'({head_el_r, head_az_r});

  logic signed [EL_W-1:0] head_el_s;
  assign head_el_s = head_el_r;

  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer overfilled");

  a_az_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (RND_W'(head_az_r) < AZ_FULL))
    else $error("azimuth at or above 360 degrees");

  a_el_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (head_el_s <= EL_RIGHT) && (head_el_s >= EL_LEFT))
    else $error("elevation beyond +-90 degrees");

endmodule

/* tb/tb.sv */
// Self-checking bench for vector_azimuth_elevation: directed corner vectors,
// then random vectors under random source gaps and sink stalls, then a long
// sink hold so the pipeline and the output buffer fill and in_tready drops.
// Every accepted word is predicted in SystemVerilog and compared in order.
module tb;

  localparam int COORD_W  = vae_pkg::COORD_WIDTH_DEF;
  localparam int FRAC_W   = vae_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int STEPS    = vae_pkg::CORDIC_STEPS_DEF;
  localparam int IN_W     = ((3 * COORD_W + 7) / 8) * 8;
  localparam int AZ_W     = FRAC_W + 9;
  localparam int EL_W     = FRAC_W + 8;
  localparam int OUT_W    = ((AZ_W + EL_W + 7) / 8) * 8;
  localparam int PIPE_LAT = 2 * STEPS + 5;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_GAP        = 16;

  // Angle math constants: 180/pi in Q48, K/2 in Q32, limits in degrees with FRAC_W fraction bits
  localparam int                 ANGQ        = 48;
  localparam longint unsigned    DEG_RAD_Q48 = 64'd16127328204063727;
  localparam longint unsigned    K_HALF_Q32  = 64'd3536390726;
  localparam longint             AZ_FULL     = longint'(360) <<< FRAC_W;
  localparam longint             EL_RIGHT    = longint'(90) <<< FRAC_W;

  localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] C_MIN = 32'h8000_0000;
  localparam logic [31:0] C_M1  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] ang;
  } rot_t;

  typedef struct packed {
    logic [IN_W-1:0]         coords;
    logic [AZ_W-1:0]         az;
    logic signed [EL_W-1:0]  el;
  } angle_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;   // coord_x, coord_y, coord_z
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;       // azimuth_deg, elevation_deg, pad

  angle_word_t pending_angles[$];
  angle_word_t want;
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int          tx_gap_max = MAX_GAP;
  int          rx_stall_max = MAX_GAP;
  int          rx_hold = 0;

  vector_azimuth_elevation u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // CORDIC vectoring: drives y to zero, accumulates the angle in Q48 degrees
  function automatic rot_t cordic_vectoring(input longint x0, input longint y0,
                                            input longint a0);
    longint          x, y, ang, dx, dy, step_ang;
    longint unsigned term;
    int              i, k;
    rot_t            r;
    x = x0;
    y = y0;
    ang = a0;
    for (i = 0; i < STEPS; i++) begin
      if (i == 0) begin
        step_ang = longint'(45) <<< ANGQ;
      end else begin
        // atan(2^-i) * 180/pi from the truncated series
        step_ang = 0;
        for (k = 0; i * (2 * k + 1) < 64; k++) begin
          term = (DEG_RAD_Q48 >> (i * (2 * k + 1))) / longint'(2 * k + 1);
          if (k % 2 == 1) step_ang = step_ang - longint'(term);
          else step_ang = step_ang + longint'(term);
        end
      end
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        ang = ang + step_ang;
      end else begin
        x = x - dx;
        y = y + dy;
        ang = ang - step_ang;
      end
    end
    r.x = x;
    r.y = y;
    r.ang = ang;
    return r;
  endfunction

  // Q48 -> FRAC_W fraction bits, round half up
  function automatic longint round_angle_q(input longint ang);
    return (ang + (longint'(1) <<< (ANGQ - FRAC_W - 1))) >>> (ANGQ - FRAC_W);
  endfunction

  function automatic angle_word_t predict_angles(input logic signed [31:0] cx,
                                                 input logic signed [31:0] cy,
                                                 input logic signed [31:0] cz);
    longint          x, y, z, xs, ys, zs, az, el, ang;
    longint unsigned zmag, zprod;
    rot_t            r;
    angle_word_t     res;
    x = cx;
    y = cy;
    z = cz;
    res.coords = {cz, cy, cx};
    res.az = '0;
    res.el = '0;
    if (x == 0 && y == 0 && z == 0) return res;
    xs = x <<< (60 - COORD_W);
    ys = y <<< (60 - COORD_W);
    zs = z <<< (60 - COORD_W);
    az = 0;
    if (!(x == 0 && y == 0)) begin
      // left half-plane: fold over and start from 180
      ang = 0;
      if (xs < 0) begin
        xs = -xs;
        ys = -ys;
        ang = longint'(180) <<< ANGQ;
      end
      r = cordic_vectoring(xs, ys, ang);
      xs = r.x;
      ang = r.ang;
      if (ang < 0) ang = ang + (longint'(360) <<< ANGQ);
      az = round_angle_q(ang);
      if (az >= AZ_FULL) az = az - AZ_FULL;
      if (az < 0) az = 0;
    end
    // z times the CORDIC gain, so it matches the scale of the folded x
    zmag = (zs < 0) ? -zs : zs;
    zprod = (zmag >> 32) * K_HALF_Q32 + (((zmag & 64'hFFFF_FFFF) * K_HALF_Q32) >> 32);
    zs = (zs < 0) ? -longint'(zprod * 2) : longint'(zprod * 2);
    r = cordic_vectoring(xs, zs, 0);
    el = round_angle_q(r.ang);
    if (el > EL_RIGHT) el = EL_RIGHT;
    if (el < -EL_RIGHT) el = -EL_RIGHT;
    res.az = az[AZ_W-1:0];
    res.el = el[EL_W-1:0];
    return res;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("tb: mismatch at %0t: %s", $realtime, msg);
  endtask

  // Offers one vector after a random gap, waits for the handshake
  task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {z, y, x};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_angles.push_back(predict_angles(x, y, z));
  endtask

  function automatic logic [31:0] scaled_coord();
    int          k;
    logic [31:0] v;
    k = $urandom_range(0, 31);
    v = $urandom & ((32'd1 << k) - 32'd1);
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  task automatic test_directed_vectors();
    send_vector(0, 0, 0);               // zero vector
    send_vector(1, 0, 0);
    send_vector(0, 1, 0);
    send_vector(C_M1, 0, 0);            // 180
    send_vector(0, C_M1, 0);            // 270
    send_vector(0, 0, 1);               // straight up, no XY part
    send_vector(0, 0, C_M1);            // straight down
    send_vector(C_MAX, 0, 0);
    send_vector(C_MIN, 0, 0);
    send_vector(0, C_MAX, 0);
    send_vector(0, C_MIN, 0);
    send_vector(0, 0, C_MAX);
    send_vector(0, 0, C_MIN);
    send_vector(C_MAX, C_MAX, C_MAX);
    send_vector(C_MIN, C_MIN, C_MIN);
    send_vector(C_MIN, C_MAX, C_MIN);
    send_vector(C_M1, C_M1, C_M1);
    send_vector(C_MAX, C_M1, 0);        // just under 360, rounds to wrap
    send_vector(C_MIN, C_M1, 0);        // just past 180
    send_vector(1, 1, 1);
    send_vector(1, 0, C_MAX);           // elevation pinned near +90
    send_vector(C_M1, 0, C_MIN);        // and near -90
    send_vector(32'h5555_5555, 32'hAAAA_AAAA, 32'h5A5A_5A5A);
    send_vector(32'hAAAA_AAAA, 32'h5555_5555, 32'hA5A5_A5A5);
    send_vector(C_MAX, 1, C_M1);
  endtask

  task automatic test_random_vectors();
    int          n, mode;
    logic [31:0] x, y, z;
    for (n = 0; n < 400; n++) begin
      // new idling mix every 50 words; first stretch runs at full rate
      if (n % 50 == 0) begin
        tx_gap_max = (n == 0) ? 0 : MAX_GAP * $urandom_range(0, 1);
        rx_stall_max = (n == 0) ? 0 : MAX_GAP * $urandom_range(0, 1);
      end
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
        send_vector($urandom, $urandom, $urandom);
      end else if (mode < 8) begin
        send_vector(scaled_coord(), scaled_coord(), scaled_coord());
      end else begin
        x = ($urandom_range(0, 1) == 1) ? 32'd0 : scaled_coord();
        y = ($urandom_range(0, 1) == 1) ? 32'd0 : scaled_coord();
        z = ($urandom_range(0, 1) == 1) ? 32'd0 : scaled_coord();
        send_vector(x, y, z);
      end
    end
  endtask

  task automatic test_output_backpressure();
    int n;
    tx_gap_max = 0;
    rx_stall_max = 0;
    rx_hold = HOLD_CYCLES;
    for (n = 0; n < 80; n++) send_vector($urandom, $urandom, scaled_coord());
    rx_stall_max = MAX_GAP;
    tx_gap_max = MAX_GAP;
    for (n = 0; n < 20; n++) send_vector($urandom, $urandom, $urandom);
  endtask

  // Sink: random stall before each word, one long hold on request
  initial begin : sink
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end else begin
        stall = $urandom_range(0, rx_stall_max);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Result check, in order against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_angles.size() == 0) begin
        log_mismatch($sformatf("unexpected word %h", out_tdata));
      end else begin
        want = pending_angles.pop_front();
        if (out_tdata[AZ_W-1:0] !== want.az)
          log_mismatch($sformatf("in %h azimuth exp %h got %h", want.coords, want.az,
                                 out_tdata[AZ_W-1:0]));
        if (out_tdata[AZ_W+EL_W-1:AZ_W] !== want.el)
          log_mismatch($sformatf("in %h elevation exp %h got %h", want.coords, want.el,
                                 out_tdata[AZ_W+EL_W-1:AZ_W]));
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_vectors();
    test_random_vectors();
    test_output_backpressure();
    in_tvalid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (mismatch_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
